/* sv/sweep_and_prune_pairs_core_assert.svh */
// Assertion macros for the sweep-and-prune pair core.
`ifndef SWEEP_AND_PRUNE_PAIRS_CORE_ASSERT_SVH
`define SWEEP_AND_PRUNE_PAIRS_CORE_ASSERT_SVH

// Antecedent holds, consequent holds in the same cycle.
`define SPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent holds, consequent holds in the next cycle.
`define SPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/spa_pkg.sv */
// Shared types and codes for the sweep-and-prune pair core.
`default_nettype none
package spa_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_PAIR   = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic               op;
        logic [5:0]         object_index;
        logic signed [31:0] low_edge;
        logic signed [31:0] high_edge;
    } spa_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] first_object;
        logic [5:0] second_object;
    } spa_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT_SCAN,
        S_SORT_DRAIN,
        S_SORT_WRITE,
        S_EDGE_RD,
        S_EDGE
    } spa_state_t;

endpackage
`default_nettype wire

/* sv/spa_edge_cmp.sv */
// Edge ordering comparator: key, then lower before upper, then object index.
`default_nettype none
module spa_edge_cmp
    import spa_pkg::*;
#(
    parameter int EB = 32,
    parameter int OW = 6
) (
    input  wire logic signed [EB-1:0] key_a,
    input  wire logic                 kind_a,
    input  wire logic [OW-1:0]        obj_a,
    input  wire logic signed [EB-1:0] key_b,
    input  wire logic                 kind_b,
    input  wire logic [OW-1:0]        obj_b,
    output logic                      a_first
);

    always_comb
    begin
        if (key_a != key_b)
            a_first = (key_a < key_b);
        else if (kind_a != kind_b)
            a_first = (kind_a < kind_b);
        else
            a_first = (obj_a < obj_b);
    end

endmodule
`default_nettype wire

/* sv/sweep_and_prune_pairs_core.sv */
// Top level of the single-axis sweep-and-prune pair core.
`default_nettype none
// Usage
//  - Command channel: cmd is taken on a clock edge with start high and busy low.
//    op load writes one object's bounds; op fetch returns the next overlapping pair or done.
//  - Result channel: done pulses for one cycle with result; no back-pressure.
//  - Config: cfg_we writes object_count (clamped to MAX_OBJECTS) and restarts the sweep.
//  - Latency: a load answers the cycle after it is taken, busy never rises.
//  - First fetch after a load or count write ranks all edges, two per object, with one
//    shared comparator, edge i against every edge j in turn; ranks are written
//    to the sorted-edge memory.
//  - Every fetch then resumes the sorted-edge walk: it reads each edge; lower edges
//    test open-set bits one bit a cycle, pausing at each pair until the next fetch.
//  - Reset clears control state, count, open set and marks a sort as needed;
//    the bound and sorted-edge memories are not cleared.
//  - Results are registered; done rises in the cycle after the last working cycle.
module sweep_and_prune_pairs_core
    import spa_pkg::*;
#(
    parameter int MAX_OBJECTS = 64,
    parameter int EDGE_BITS   = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire spa_in_t  cmd,
    output logic          done,
    output spa_out_t      result,
    input  wire logic     cfg_we,
    input  wire logic [6:0] cfg_data
);

    localparam int OW    = $clog2(MAX_OBJECTS);        // object index
    localparam int EW    = OW + 1;                     // edge id
    localparam int SC_W  = $clog2(MAX_OBJECTS + 1);    // count of objects
    localparam int EP_W  = $clog2(2 * MAX_OBJECTS + 1);// count of edges
    localparam int EDGES = 2 * MAX_OBJECTS;
    localparam logic [SC_W-1:0] MAX_N = SC_W'(MAX_OBJECTS);

    // state
    spa_state_t state_reg, state_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic            sort_needed_reg, sort_needed_next;
    logic [EP_W-1:0] edge_pos_reg, edge_pos_next;
    logic [SC_W-1:0] scan_reg, scan_next;
    logic [MAX_OBJECTS-1:0] open_reg, open_next;
    logic [EW-1:0]   i_reg, i_next;
    logic [EW-1:0]   j_reg, j_next;
    logic [EW-1:0]   pj_reg, pj_next;
    logic [EW-1:0]   rank_reg, rank_next;
    logic            cmp_vld_reg, cmp_vld_next;
    logic            done_reg, done_next;
    spa_out_t        result_reg, result_next;

    // memories
    logic [2*EDGE_BITS-1:0] key_mem [MAX_OBJECTS];
    logic [EW-1:0]          sorted_mem [EDGES];
    logic [2*EDGE_BITS-1:0] row_a_q, row_b_q;
    logic [EW-1:0]          sorted_q;

    logic                   key_we;
    logic [OW-1:0]          key_waddr;
    logic [2*EDGE_BITS-1:0] key_wdata;
    logic                   sorted_we;

    logic [SC_W-1:0] n_obj;
    logic [EP_W-1:0] m_edge;
    logic            accept;
    logic            idx_bad;
    logic            j_first;
    logic signed [EDGE_BITS-1:0] key_i, key_j;
    logic [OW-1:0]   cur_obj;
    logic            cur_kind;

    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign n_obj   = (int'(cnt_reg) > MAX_OBJECTS) ? MAX_N : SC_W'(cnt_reg);
    assign m_edge  = EP_W'({n_obj, 1'b0});
    assign idx_bad = (int'(cmd.object_index) >= MAX_OBJECTS);

    assign key_we    = accept && (cmd.op == OP_LOAD) && !idx_bad;
    assign key_waddr = OW'(cmd.object_index);
    assign key_wdata = {EDGE_BITS'(cmd.high_edge), EDGE_BITS'(cmd.low_edge)};
    assign sorted_we = (state_reg == S_SORT_WRITE);

    // bound rows: {upper, lower}; port a follows edge i, port b edge j
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_waddr] <= key_wdata;
        row_a_q <= key_mem[i_reg[EW-1:1]];
        row_b_q <= key_mem[j_reg[EW-1:1]];
    end

    always_ff @(posedge clk)
    begin
        if (sorted_we)
            sorted_mem[rank_reg] <= i_reg;
        sorted_q <= sorted_mem[edge_pos_reg[EW-1:0]];
    end

    assign key_i = i_reg[0]  ? $signed(row_a_q[2*EDGE_BITS-1:EDGE_BITS])
                             : $signed(row_a_q[EDGE_BITS-1:0]);
    assign key_j = pj_reg[0] ? $signed(row_b_q[2*EDGE_BITS-1:EDGE_BITS])
                             : $signed(row_b_q[EDGE_BITS-1:0]);

    spa_edge_cmp #(
        .EB (EDGE_BITS),
        .OW (OW)
    ) u_cmp (
        .key_a   (key_j),
        .kind_a  (pj_reg[0]),
        .obj_a   (pj_reg[EW-1:1]),
        .key_b   (key_i),
        .kind_b  (i_reg[0]),
        .obj_b   (i_reg[EW-1:1]),
        .a_first (j_first)
    );

    assign cur_obj  = sorted_q[EW-1:1];
    assign cur_kind = sorted_q[0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.op == OP_FETCH)
                begin
                    if (sort_needed_reg && m_edge != '0)
                        state_next = S_SORT_SCAN;
                    else
                        state_next = S_EDGE_RD;
                end
            end
            S_SORT_SCAN:
            begin
                if (EP_W'(j_reg) + EP_W'(1) == m_edge)
                    state_next = S_SORT_DRAIN;
            end
            S_SORT_DRAIN:
                state_next = S_SORT_WRITE;
            S_SORT_WRITE:
            begin
                if (EP_W'(i_reg) + EP_W'(1) == m_edge)
                    state_next = S_EDGE_RD;
                else
                    state_next = S_SORT_SCAN;
            end
            S_EDGE_RD:
            begin
                if (edge_pos_reg >= m_edge)
                    state_next = S_IDLE;
                else
                    state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if (cur_kind)
                    state_next = S_EDGE_RD;
                else if (scan_reg >= n_obj)
                    state_next = S_EDGE_RD;
                else if (open_reg[scan_reg[OW-1:0]])
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and result
    always_comb
    begin
        cnt_next         = cnt_reg;
        sort_needed_next = sort_needed_reg;
        edge_pos_next    = edge_pos_reg;
        scan_next        = scan_reg;
        open_next        = open_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        pj_next          = pj_reg;
        rank_next        = rank_reg;
        cmp_vld_next     = 1'b0;
        done_next        = 1'b0;
        result_next      = '0;

        if (cmp_vld_reg && j_first)
            rank_next = rank_reg + EW'(1);

        if (cfg_we)
        begin
            cnt_next         = cfg_data;
            sort_needed_next = 1'b1;
            edge_pos_next    = '0;
            scan_next        = '0;
            open_next        = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd.op == OP_LOAD)
                begin
                    done_next = 1'b1;
                    if (idx_bad)
                        result_next.status = ST_RANGE;
                    else
                    begin
                        result_next.status = ST_LOADED;
                        sort_needed_next   = 1'b1;
                        edge_pos_next      = '0;
                        scan_next          = '0;
                        open_next          = '0;
                    end
                end
                else if (accept && sort_needed_reg)
                begin
                    // empty sweep needs no ranking
                    sort_needed_next = (m_edge != '0);
                    edge_pos_next    = '0;
                    scan_next        = '0;
                    open_next        = '0;
                    i_next           = '0;
                    j_next           = '0;
                    rank_next        = '0;
                end
            end
            S_SORT_SCAN:
            begin
                cmp_vld_next = 1'b1;
                pj_next      = j_reg;
                j_next       = j_reg + EW'(1);
            end
            S_SORT_DRAIN:
                cmp_vld_next = 1'b0;
            S_SORT_WRITE:
            begin
                rank_next = '0;
                j_next    = '0;
                if (EP_W'(i_reg) + EP_W'(1) == m_edge)
                    sort_needed_next = 1'b0;
                else
                    i_next = i_reg + EW'(1);
            end
            S_EDGE_RD:
            begin
                if (edge_pos_reg >= m_edge)
                begin
                    done_next          = 1'b1;
                    result_next.status = ST_DONE;
                end
            end
            S_EDGE:
            begin
                if (cur_kind)
                begin
                    open_next[cur_obj] = 1'b0;
                    edge_pos_next      = edge_pos_reg + EP_W'(1);
                end
                else if (scan_reg >= n_obj)
                begin
                    open_next[cur_obj] = 1'b1;
                    scan_next          = '0;
                    edge_pos_next      = edge_pos_reg + EP_W'(1);
                end
                else if (open_reg[scan_reg[OW-1:0]])
                begin
                    done_next          = 1'b1;
                    result_next.status = ST_PAIR;
                    if (scan_reg[OW-1:0] < cur_obj)
                    begin
                        result_next.first_object  = 6'(scan_reg[OW-1:0]);
                        result_next.second_object = 6'(cur_obj);
                    end
                    else
                    begin
                        result_next.first_object  = 6'(cur_obj);
                        result_next.second_object = 6'(scan_reg[OW-1:0]);
                    end
                    scan_next = scan_reg + SC_W'(1);
                end
                else
                    scan_next = scan_reg + SC_W'(1);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            sort_needed_reg <= 1'b1;
            edge_pos_reg    <= '0;
            scan_reg        <= '0;
            open_reg        <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
            pj_reg          <= '0;
            rank_reg        <= '0;
            cmp_vld_reg     <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            sort_needed_reg <= sort_needed_next;
            edge_pos_reg    <= edge_pos_next;
            scan_reg        <= scan_next;
            open_reg        <= open_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            pj_reg          <= pj_next;
            rank_reg        <= rank_next;
            cmp_vld_reg     <= cmp_vld_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`include "sweep_and_prune_pairs_core_assert.svh"

    `SPA_ASSERT_NOW(a_pair_order, done && result.status == ST_PAIR, result.first_object < result.second_object, "pair not in ascending order")
    `SPA_ASSERT_NEXT(a_load_answer, accept && cmd.op == OP_LOAD, done && !busy, "load not answered next cycle")
    `SPA_ASSERT_NOW(a_rank_bound, state_reg == S_SORT_WRITE, EP_W'(rank_reg) < m_edge, "edge rank beyond edge count")
    `SPA_ASSERT_NOW(a_idle_quiet, done && busy, 1'b0, "result given while still working")

endmodule
`default_nettype wire
